>>> hw/rtl/hnd_pkg.sv
// Shared types, codes and helper functions for the HDLC NRZI deframer.
// Used by hnd_front, hnd_evq, hnd_back and the top level; no dependencies.
package hnd_pkg;

    localparam int MAX_FRAME  = 256;
    localparam int CNT_W      = $clog2(MAX_FRAME);
    // Queue depths must be powers of two so the pointers wrap on their own.
    localparam int EVQ_DEPTH  = 2;
    localparam int EVQ_AW     = $clog2(EVQ_DEPTH);
    localparam int RESQ_DEPTH = 2;
    localparam int RESQ_AW    = $clog2(RESQ_DEPTH);

    localparam logic [15:0] CRC_INIT    = 16'hFFFF;
    localparam logic [15:0] CRC_POLY    = 16'h8408;
    localparam logic [15:0] CRC_RESIDUE = 16'hF0B8;

    // Frame tracking state codes
    localparam logic [1:0] ST_WAIT_FLAG  = 2'd0;
    localparam logic [1:0] ST_WAIT_FRAME = 2'd1;
    localparam logic [1:0] ST_IN_FRAME   = 2'd2;

    // Result kinds
    localparam logic [1:0] KIND_DATA    = 2'd0;
    localparam logic [1:0] KIND_GOOD    = 2'd1;
    localparam logic [1:0] KIND_DISCARD = 2'd2;

    // Event codes from front to back
    localparam logic [1:0] EV_DATA    = 2'd0;
    localparam logic [1:0] EV_END     = 2'd1;
    localparam logic [1:0] EV_DISCARD = 2'd2;

    typedef struct packed {
        logic [1:0] op;
        logic       first;
        logic [7:0] data;
        logic [7:0] len;
    } ev_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic [7:0] len;
    } res_t;

    // Reflected CRC-16 X.25, one byte
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // Saturate the frame byte count to the 8-bit length field
    function automatic logic [7:0] sat_len(input logic [CNT_W-1:0] cnt);
        logic [15:0] w;
        w = 16'(cnt);
        return (w > 16'd255) ? 8'hFF : w[7:0];
    endfunction

endpackage

>>> hw/rtl/hnd_front.sv
// Front end: NRZI decode, ones-run tracking, destuffing, byte assembly and
// frame bookkeeping; emits one event per byte, closing flag or discard.
// Depends on hnd_pkg.
module hnd_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  logic               rx_bit,
    output logic               ev_push,
    output hnd_pkg::ev_t       ev
);

    logic                        last_reg, last_next;
    logic [3:0]                  run_reg, run_next;
    logic [2:0]                  pos_reg, pos_next;
    logic [7:0]                  shift_reg, shift_next;
    logic [1:0]                  fs_reg, fs_next;
    logic [hnd_pkg::CNT_W-1:0]   cnt_reg, cnt_next;

    logic                        bit_dec;
    logic [3:0]                  run_inc;
    logic                        shift_in;
    logic                        byte_live;
    logic                        first;
    logic [hnd_pkg::CNT_W-1:0]   cnt_base;
    logic                        emit;
    hnd_pkg::ev_t                ev_c;

    always_comb
    begin
        last_next  = rx_bit;
        run_next   = run_reg;
        pos_next   = pos_reg;
        shift_next = shift_reg;
        fs_next    = fs_reg;
        cnt_next   = cnt_reg;
        emit       = 1'b0;
        ev_c       = '0;
        shift_in   = 1'b0;
        byte_live  = 1'b0;
        first      = 1'b0;
        cnt_base   = cnt_reg;

        bit_dec = ~(rx_bit ^ last_reg);
        run_inc = (run_reg < 4'd8) ? run_reg + 4'd1 : run_reg;

        if (bit_dec)
        begin
            run_next = run_inc;
            if (run_inc == 4'd7)
            begin
                // abort: drop any open frame
                if (fs_reg == hnd_pkg::ST_IN_FRAME)
                begin
                    emit    = 1'b1;
                    ev_c.op = hnd_pkg::EV_DISCARD;
                    ev_c.len = hnd_pkg::sat_len(cnt_reg);
                end
                fs_next    = hnd_pkg::ST_WAIT_FLAG;
                shift_next = '0;
                pos_next   = '0;
                cnt_next   = '0;
            end
            else if (run_inc < 4'd7)
            begin
                shift_in = 1'b1;
            end
        end
        else
        begin
            run_next = '0;
            if (run_reg > 4'd6)
            begin
                fs_next    = hnd_pkg::ST_WAIT_FLAG;
                shift_next = '0;
                pos_next   = '0;
                cnt_next   = '0;
            end
            else if (run_reg == 4'd6)
            begin
                // flag: close the open frame, wait for the next first byte
                if (fs_reg == hnd_pkg::ST_IN_FRAME)
                begin
                    emit     = 1'b1;
                    ev_c.op  = hnd_pkg::EV_END;
                    ev_c.len = hnd_pkg::sat_len(cnt_reg);
                end
                fs_next    = hnd_pkg::ST_WAIT_FRAME;
                shift_next = '0;
                pos_next   = '0;
                cnt_next   = '0;
            end
            else if (run_reg != 4'd5)
            begin
                shift_in = 1'b1;
            end
        end

        if (shift_in)
        begin
            shift_next = {bit_dec, shift_reg[7:1]};
            if (pos_reg != 3'd7)
            begin
                pos_next = pos_reg + 3'd1;
            end
            else
            begin
                pos_next  = '0;
                byte_live = (fs_reg == hnd_pkg::ST_IN_FRAME);
                if (fs_reg == hnd_pkg::ST_WAIT_FRAME)
                begin
                    byte_live = 1'b1;
                    first     = 1'b1;
                    fs_next   = hnd_pkg::ST_IN_FRAME;
                    cnt_base  = '0;
                end
                if (byte_live)
                begin
                    emit = 1'b1;
                    if (cnt_base == hnd_pkg::CNT_W'(hnd_pkg::MAX_FRAME - 1))
                    begin
                        // overflow: drop the frame
                        ev_c.op    = hnd_pkg::EV_DISCARD;
                        ev_c.len   = hnd_pkg::sat_len(cnt_base);
                        run_next   = '0;
                        fs_next    = hnd_pkg::ST_WAIT_FLAG;
                        shift_next = '0;
                        cnt_next   = '0;
                    end
                    else
                    begin
                        cnt_next   = cnt_base + hnd_pkg::CNT_W'(1);
                        ev_c.op    = hnd_pkg::EV_DATA;
                        ev_c.first = first;
                        ev_c.data  = {bit_dec, shift_reg[7:1]};
                        ev_c.len   = hnd_pkg::sat_len(cnt_next);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg  <= 1'b0;
            run_reg   <= '0;
            pos_reg   <= '0;
            shift_reg <= '0;
            fs_reg    <= hnd_pkg::ST_WAIT_FLAG;
            cnt_reg   <= '0;
        end
        else if (accept)
        begin
            last_reg  <= last_next;
            run_reg   <= run_next;
            pos_reg   <= pos_next;
            shift_reg <= shift_next;
            fs_reg    <= fs_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign ev_push = accept && emit;
    assign ev      = ev_c;

`ifndef SYNTH
    a_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
        fs_reg != hnd_pkg::ST_IN_FRAME |-> cnt_reg == '0)
        else $error("byte count nonzero outside a frame");
    a_byte_align: assert property (@(posedge clk) disable iff (!rst_n)
        ev_push && ev.op == hnd_pkg::EV_DATA |=> pos_reg == '0)
        else $error("data byte emitted off byte boundary");
`endif

endmodule

>>> hw/rtl/hnd_evq.sv
// Short event queue between the front end and the CRC/result back end.
// Depends on hnd_pkg.
module hnd_evq (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  hnd_pkg::ev_t  wdata,
    output logic          full,
    input  logic          pop,
    output logic          empty,
    output hnd_pkg::ev_t  rdata
);

    hnd_pkg::ev_t                 mem_reg [hnd_pkg::EVQ_DEPTH];
    logic [hnd_pkg::EVQ_AW-1:0]   wr_ptr_reg;
    logic [hnd_pkg::EVQ_AW-1:0]   rd_ptr_reg;
    logic [hnd_pkg::EVQ_AW:0]     count_reg, count_next;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + (hnd_pkg::EVQ_AW + 1)'(1);
        else if (pop && !push)
            count_next = count_reg - (hnd_pkg::EVQ_AW + 1)'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + hnd_pkg::EVQ_AW'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + hnd_pkg::EVQ_AW'(1);
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= wdata;
    end

    assign full  = (count_reg == (hnd_pkg::EVQ_AW + 1)'(hnd_pkg::EVQ_DEPTH));
    assign empty = (count_reg == '0);
    assign rdata = mem_reg[rd_ptr_reg];

`ifndef SYNTH
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("event pushed into full queue");
`endif

endmodule

>>> hw/rtl/hnd_back.sv
// Back end: streaming CRC-16 X.25, closing-flag verdict and result queue.
// Holds the min_length register. Depends on hnd_pkg.
module hnd_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic [7:0]    cfg_wdata,
    input  logic          ev_empty,
    input  hnd_pkg::ev_t  ev,
    output logic          ev_pop,
    output logic          empty,
    input  logic          pop,
    output hnd_pkg::res_t res
);

    logic [7:0]                    min_len_reg;
    logic [15:0]                   crc_reg, crc_next;
    hnd_pkg::res_t                 q_reg [hnd_pkg::RESQ_DEPTH];
    logic [hnd_pkg::RESQ_AW-1:0]   wr_ptr_reg;
    logic [hnd_pkg::RESQ_AW-1:0]   rd_ptr_reg;
    logic [hnd_pkg::RESQ_AW:0]     count_reg, count_next;
    logic                          res_full;
    logic                          res_pop;
    logic [15:0]                   crc_base;
    hnd_pkg::res_t                 res_c;

    assign res_full = (count_reg == (hnd_pkg::RESQ_AW + 1)'(hnd_pkg::RESQ_DEPTH));
    assign empty    = (count_reg == '0);
    assign res_pop  = pop && !empty;
    assign ev_pop   = !ev_empty && !res_full;

    always_comb
    begin
        crc_base   = ev.first ? hnd_pkg::CRC_INIT : crc_reg;
        crc_next   = crc_reg;
        res_c.kind = hnd_pkg::KIND_DISCARD;
        res_c.data = '0;
        res_c.len  = ev.len;
        unique case (ev.op)
            hnd_pkg::EV_DATA:
            begin
                crc_next   = hnd_pkg::crc_byte(crc_base, ev.data);
                res_c.kind = hnd_pkg::KIND_DATA;
                res_c.data = ev.data;
            end
            hnd_pkg::EV_END:
            begin
                if (ev.len >= min_len_reg && crc_reg == hnd_pkg::CRC_RESIDUE)
                    res_c.kind = hnd_pkg::KIND_GOOD;
            end
            default:
            begin
                res_c.kind = hnd_pkg::KIND_DISCARD;
            end
        endcase
    end

    always_comb
    begin
        count_next = count_reg;
        if (ev_pop && !res_pop)
            count_next = count_reg + (hnd_pkg::RESQ_AW + 1)'(1);
        else if (res_pop && !ev_pop)
            count_next = count_reg - (hnd_pkg::RESQ_AW + 1)'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_len_reg <= 8'd18;
            crc_reg     <= hnd_pkg::CRC_INIT;
            wr_ptr_reg  <= '0;
            rd_ptr_reg  <= '0;
            count_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
                min_len_reg <= cfg_wdata;
            if (ev_pop)
            begin
                crc_reg    <= crc_next;
                wr_ptr_reg <= wr_ptr_reg + hnd_pkg::RESQ_AW'(1);
            end
            if (res_pop)
                rd_ptr_reg <= rd_ptr_reg + hnd_pkg::RESQ_AW'(1);
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ev_pop)
            q_reg[wr_ptr_reg] <= res_c;
    end

    assign res = q_reg[rd_ptr_reg];

`ifndef SYNTH
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (hnd_pkg::RESQ_AW + 1)'(hnd_pkg::RESQ_DEPTH))
        else $error("result queue count out of range");
    a_data_nonzero_len: assert property (@(posedge clk) disable iff (!rst_n)
        ev_pop && ev.op == hnd_pkg::EV_DATA |-> ev.len != '0)
        else $error("data byte with zero frame length");
`endif

endmodule

>>> hw/rtl/hdlc_nrzi_deframer_crc_check.sv
// HDLC deframer with NRZI decode and CRC-16 X.25 check, top level.
// Instantiates hnd_front, hnd_evq and hnd_back; depends on hnd_pkg.
//
// One sliced line bit enters per transaction, one per clock when the result
// side keeps up; full rises only when the two-entry event queue fills because
// results are not being popped. A bit yields at most one result: a data byte
// (kind 0) as soon as its eighth destuffed bit arrives, or a frame verdict
// (kind 1 good, kind 2 discarded) on a closing flag, abort or overflow. A
// result passes via the event queue to the result queue: the front end decodes,
// destuffs and assembles bytes in the accepting cycle and writes the event
// queue at that edge; the back end folds the byte into the CRC as it moves the
// event on once the result queue has room. min_length resets to 18; the user
// must write it via cfg_we/cfg_wdata only while the block is idle (unenforced).
module hdlc_nrzi_deframer_crc_check (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,
    input  logic        push,
    output logic        full,
    input  logic        rx_bit,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  kind,
    output logic [7:0]  data_byte,
    output logic [7:0]  frame_length
);

    logic           accept;
    logic           ev_push;
    hnd_pkg::ev_t   ev_in;
    logic           ev_pop;
    logic           ev_empty;
    hnd_pkg::ev_t   ev_out;
    hnd_pkg::res_t  res;

    assign accept = push && !full;

    hnd_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .rx_bit  (rx_bit),
        .ev_push (ev_push),
        .ev      (ev_in)
    );

    hnd_evq u_evq (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (ev_push),
        .wdata (ev_in),
        .full  (full),
        .pop   (ev_pop),
        .empty (ev_empty),
        .rdata (ev_out)
    );

    hnd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .ev_empty  (ev_empty),
        .ev        (ev_out),
        .ev_pop    (ev_pop),
        .empty     (empty),
        .pop       (pop),
        .res       (res)
    );

    assign kind         = res.kind;
    assign data_byte    = res.data;
    assign frame_length = res.len;

endmodule
